>>> design/symbol_table_greedy_encoder_defines.svh
// Assertion macros used by the top encoder module.
`ifndef SYMBOL_TABLE_GREEDY_ENCODER_DEFINES_SVH
`define SYMBOL_TABLE_GREEDY_ENCODER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define STGE_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define STGE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/stge_pkg.sv
`default_nettype none
package stge_pkg;
    localparam int unsigned WIN_BYTES = 8;
    localparam logic [7:0]  ESC_CODE  = 8'd255;
    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_MATCH  = 1'b1;
    localparam logic [1:0]  REG_SYMBOL_COUNT = 2'd0;

    typedef struct packed {
        logic [63:0] window;
        logic [3:0]  limit;
        logic [7:0]  count;
        logic [3:0]  top_len;
        logic [7:0]  top_code;
        logic        active;
    } stge_token_t;
endpackage
`default_nettype wire

>>> design/stge_cell.sv
`default_nettype none
module stge_cell
#(
    parameter logic [7:0] INDEX = 8'd0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load_en,
    input  wire logic [63:0] load_bytes,
    input  wire logic [3:0]  load_length,
    input  wire stge_pkg::stge_token_t tok_in,
    output stge_pkg::stge_token_t tok_out
);
    import stge_pkg::*;

    logic [63:0] sym_reg;
    logic [3:0]  len_reg;
    stge_token_t tok_reg;
    stge_token_t tok_next;
    logic [63:0] mask;
    logic        hit;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sym_reg <= load_bytes;
            len_reg <= load_length;
        end
    end

    always_comb
    begin
        mask = '0;
        for (int b = 0; b < WIN_BYTES; b++)
        begin
            if (4'(b) < len_reg)
            begin
                mask[b*8 +: 8] = 8'hFF;
            end
        end
        hit = (INDEX < tok_in.count) && (len_reg != 4'd0) && (len_reg <= tok_in.limit)
              && (len_reg > tok_in.top_len) && (((sym_reg ^ tok_in.window) & mask) == '0);
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.top_len  = len_reg;
            tok_next.top_code = INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

>>> design/symbol_table_greedy_encoder.sv
`default_nettype none
// Greedy symbol-table encoder. Load items (operation 0) write one table entry and
// give no result. Match items (operation 1) pass through a row of TABLE_ENTRIES
// cells, one entry per cell, one cell per cycle; the result strobe is high while
// the item sits in the last cell's register, and busy falls after that, so no new
// item is accepted while a match item is in the row. A load item does not raise
// busy. The receiver cannot stall: each result is shown for one cycle only.
// symbol_count is written through the APB port at address 0.
module symbol_table_greedy_encoder
#(
    parameter int unsigned TABLE_ENTRIES  = 255,
    parameter int unsigned MAX_SYMBOL_LEN = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [7:0]  entry_index,
    input  wire logic [63:0] entry_bytes,
    input  wire logic [3:0]  entry_length,
    input  wire logic [63:0] window_bytes,
    input  wire logic [3:0]  window_valid,
    output logic             result_valid,
    output logic [7:0]       code_byte,
    output logic [7:0]       literal_byte,
    output logic             literal_present,
    output logic [3:0]       consumed_length
);
    import stge_pkg::*;
    `include "symbol_table_greedy_encoder_defines.svh"

    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 2);

    logic [7:0]    symbol_count_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          wr;
    logic          acc;
    stge_token_t   tok_head;
    stge_token_t   chain [TABLE_ENTRIES+1];
    stge_token_t   tail;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr == REG_SYMBOL_COUNT) ? {24'd0, symbol_count_reg} : 32'd0;
    assign acc = start && !busy_reg;
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= 8'd0;
        end
        else if (wr && paddr == REG_SYMBOL_COUNT)
        begin
            symbol_count_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        tok_head = '0;
        tok_head.window    = window_bytes;
        tok_head.limit     = (window_valid > 4'(MAX_SYMBOL_LEN)) ? 4'(MAX_SYMBOL_LEN)
                                                                 : window_valid;
        tok_head.count     = (symbol_count_reg > 8'(TABLE_ENTRIES)) ? 8'(TABLE_ENTRIES)
                                                                    : symbol_count_reg;
        tok_head.top_code  = ESC_CODE;
        tok_head.active    = acc && (operation == OP_MATCH);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (tok_head.active)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(TABLE_ENTRIES);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign chain[0] = tok_head;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        stge_cell #(.INDEX(8'(i))) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load_en     (acc && operation == OP_LOAD && entry_index == 8'(i)),
            .load_bytes  (entry_bytes),
            .load_length (entry_length),
            .tok_in      (chain[i]),
            .tok_out     (chain[i+1])
        );
    end

    assign tail = chain[TABLE_ENTRIES];
    assign result_valid = tail.active;
    assign code_byte = tail.top_code;
    assign literal_present = (tail.top_len == 4'd0);
    assign literal_byte = literal_present ? tail.window[7:0] : 8'd0;
    assign consumed_length = literal_present ? 4'd1 : tail.top_len;

    `STGE_ASSERT_IMP(a_res_busy, clk, rst_n, result_valid, busy_reg)
    `STGE_ASSERT_IMP(a_esc_code, clk, rst_n, result_valid && literal_present,
                     code_byte == ESC_CODE)
    `STGE_ASSERT_NEXT(a_start_busy, clk, rst_n, acc && operation == OP_MATCH, busy_reg)
endmodule
`default_nettype wire

>>> sim/symbol_table_greedy_encoder_test.sv
`default_nettype none
module symbol_table_greedy_encoder_test;
    import stge_pkg::*;

    localparam int unsigned ENTRIES = 255;
    localparam int unsigned MAX_LEN = 8;
    localparam int unsigned RANDOM_ITEMS = 471;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] literal;
        logic       escaped;
        logic [3:0] consumed;
    } encoding_t;

    typedef struct {
        logic        op;
        logic [7:0]  idx;
        logic [63:0] ebytes;
        logic [3:0]  elen;
        logic [63:0] wbytes;
        logic [3:0]  wvalid;
        bit          typed;
        encoding_t   want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        operation;
    logic [7:0]  entry_index;
    logic [63:0] entry_bytes;
    logic [3:0]  entry_length;
    logic [63:0] window_bytes;
    logic [3:0]  window_valid;
    logic        result_valid;
    logic [7:0]  code_byte;
    logic [7:0]  literal_byte;
    logic        literal_present;
    logic [3:0]  consumed_length;

    logic [63:0] table_bytes [ENTRIES];
    logic [3:0]  table_len [ENTRIES];
    logic [7:0]  active_count;
    encoding_t   pending_codes [$];
    int          errors;
    int          idle_pct;
    row_t        rows [$];

    symbol_table_greedy_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .operation(operation),
        .entry_index(entry_index),
        .entry_bytes(entry_bytes),
        .entry_length(entry_length),
        .window_bytes(window_bytes),
        .window_valid(window_valid),
        .result_valid(result_valid),
        .code_byte(code_byte),
        .literal_byte(literal_byte),
        .literal_present(literal_present),
        .consumed_length(consumed_length)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [63:0] prefix_bits(int unsigned n);
        if (n >= MAX_LEN)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic encoding_t greedy_encode(logic [63:0] wb, logic [3:0] wv);
        encoding_t   e;
        int unsigned lim;
        int unsigned best;
        int unsigned len;
        lim = (wv > 4'(MAX_LEN)) ? MAX_LEN : 32'(wv);
        best = 0;
        e.code = ESC_CODE;
        for (int i = 0; i < active_count && i < ENTRIES; i++)
        begin
            len = 32'(table_len[i]);
            if (len <= lim && len > best && ((table_bytes[i] ^ wb) & prefix_bits(len)) == 0)
            begin
                best = len;
                e.code = i[7:0];
            end
        end
        if (e.code == ESC_CODE)
        begin
            e.literal = wb[7:0];
            e.escaped = 1'b1;
            e.consumed = 4'd1;
        end
        else
        begin
            e.literal = 8'd0;
            e.escaped = 1'b0;
            e.consumed = best[3:0];
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_codes.size() == 0)
                report_mismatch("unexpected item", 64'(code_byte), 64'd0);
            else
            begin
                encoding_t w;
                w = pending_codes.pop_front();
                if (code_byte !== w.code)
                    report_mismatch("code_byte", 64'(code_byte), 64'(w.code));
                if (literal_byte !== w.literal)
                    report_mismatch("literal_byte", 64'(literal_byte), 64'(w.literal));
                if (literal_present !== w.escaped)
                    report_mismatch("literal_present", 64'(literal_present), 64'(w.escaped));
                if (consumed_length !== w.consumed)
                    report_mismatch("consumed_length", 64'(consumed_length), 64'(w.consumed));
            end
        end
    end

    task automatic send_item(row_t r);
        encoding_t e;
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(negedge clk);
        while (busy)
            @(negedge clk);
        start = 1'b1;
        operation = r.op;
        entry_index = r.idx;
        entry_bytes = r.ebytes;
        entry_length = r.elen;
        window_bytes = r.wbytes;
        window_valid = r.wvalid;
        @(posedge clk);
        if (r.op == OP_LOAD)
        begin
            if (r.idx < ENTRIES)
            begin
                table_bytes[r.idx] = r.ebytes;
                table_len[r.idx] = r.elen;
            end
        end
        else
        begin
            e = greedy_encode(r.wbytes, r.wvalid);
            pending_codes.push_back(r.typed ? r.want : e);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_count(logic [7:0] value);
        while (busy || pending_codes.size() != 0)
            @(negedge clk);
        repeat (ENTRIES + 8) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_SYMBOL_COUNT;
        pwdata = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
            report_mismatch("pready", 64'(pready), 64'd1);
        active_count = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, value})
            report_mismatch("prdata", 64'(prdata), 64'(value));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [63:0] pick_bytes();
        logic [63:0] b;
        b = {$urandom, $urandom};
        if ($urandom_range(1))
            for (int k = 0; k < 8; k++)
                b[8*k +: 8] = 8'($urandom_range(3));
        return b;
    endfunction

    function automatic row_t load_row(logic [7:0] idx, logic [63:0] b, logic [3:0] len);
        row_t r;
        r = '{default: '0};
        r.op = OP_LOAD;
        r.idx = idx;
        r.ebytes = b;
        r.elen = len;
        r.wbytes = {$urandom, $urandom};
        r.wvalid = 4'($urandom);
        return r;
    endfunction

    function automatic row_t match_row(logic [63:0] wb, logic [3:0] wv);
        row_t r;
        r = '{default: '0};
        r.op = OP_MATCH;
        r.idx = 8'($urandom);
        r.ebytes = {$urandom, $urandom};
        r.elen = 4'($urandom);
        r.wbytes = wb;
        r.wvalid = wv;
        return r;
    endfunction

    function automatic row_t escape_row(logic [63:0] wb, logic [3:0] wv);
        row_t r;
        r = match_row(wb, wv);
        r.typed = 1'b1;
        r.want = '{code: ESC_CODE, literal: wb[7:0], escaped: 1'b1, consumed: 4'd1};
        return r;
    endfunction

    function automatic row_t random_row();
        row_t        r;
        int unsigned j;
        int unsigned l;
        logic [63:0] wb;
        if ($urandom_range(99) < 12)
            return load_row(8'($urandom), pick_bytes(), 4'($urandom_range(99) < 85 ?
                            $urandom_range(1, MAX_LEN) : $urandom));
        wb = pick_bytes();
        if ($urandom_range(99) < 75)
        begin
            j = $urandom_range(ENTRIES - 1);
            l = (table_len[j] > 4'(MAX_LEN)) ? MAX_LEN : 32'(table_len[j]);
            wb = (table_bytes[j] & prefix_bits(l)) | (wb & ~prefix_bits(l));
        end
        return match_row(wb, 4'($urandom_range(99) < 85 ? $urandom_range(1, MAX_LEN)
                                                         : $urandom));
    endfunction

    initial
    begin
        errors = 0;
        idle_pct = 0;
        active_count = 8'd0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        operation = OP_LOAD;
        entry_index = '0;
        entry_bytes = '0;
        entry_length = 4'd1;
        window_bytes = '0;
        window_valid = 4'd1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill every slot so no unwritten entry is ever matched
        for (int i = 0; i < ENTRIES; i++)
            send_item(load_row(8'(i), pick_bytes(), 4'($urandom_range(1, MAX_LEN))));

        rows.push_back(escape_row('0, 4'd0));
        rows.push_back(escape_row('1, 4'd15));
        rows.push_back(escape_row(64'h0123_4567_89ab_cdef, 4'd8));
        rows.push_back(load_row(8'd255, '1, 4'd8));
        rows.push_back(load_row(8'd0, '1, 4'd8));
        rows.push_back(load_row(8'd1, 64'hff, 4'd1));
        rows.push_back(load_row(8'd2, 64'hffff, 4'd2));
        rows.push_back(load_row(8'd3, 64'h0, 4'd0));
        rows.push_back(load_row(8'd4, 64'h0, 4'd9));
        rows.push_back(load_row(8'd5, 64'h0, 4'd15));
        rows.push_back(load_row(8'd254, 64'h0, 4'd1));
        rows.push_back(escape_row('1, 4'd8));
        foreach (rows[i])
            send_item(rows[i]);

        write_count(8'd255);
        rows.delete();
        rows.push_back(match_row('1, 4'd8));
        rows.push_back(match_row('1, 4'd15));
        rows.push_back(match_row('1, 4'd7));
        rows.push_back(match_row(64'h00ff, 4'd1));
        rows.push_back(match_row(64'h00ff, 4'd0));
        rows.push_back(match_row('0, 4'd8));
        rows.push_back(match_row('0, 4'd0));
        rows.push_back(match_row(64'h1234_5678_9abc_def0, 4'd12));
        foreach (rows[i])
            send_item(rows[i]);

        write_count(8'd1);
        send_item(match_row('1, 4'd8));
        send_item(match_row(64'hff, 4'd8));

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 27 : (phase == 1) ? 64 : 0;
            write_count(8'(phase == 1 ? 255 : phase == 0 ? $urandom_range(2, 254) :
                           $urandom_range(1, 16)));
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_item(random_row());
        end
        write_count(8'd0);
        send_item(match_row({$urandom, $urandom}, 4'd8));

        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (ENTRIES + 10) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/stge_pkg.sv
design/stge_cell.sv
design/symbol_table_greedy_encoder.sv
sim/symbol_table_greedy_encoder_test.sv
